/* design/orle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orle_pkg
// shared types and codes for the ordered record list engine
// ----------------------------------------------------------------------------
package orle_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // insert status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_PAST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELETE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
    logic [7:0]         age;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t op;
    logic     keep;
  } cell_cmd_t;

  typedef struct packed {
    rec_t       rec;
    logic       has_record;
    logic [1:0] status;
    logic [5:0] removed;
    logic [5:0] length;
    logic       last;
  } beat_t;

endpackage : orle_pkg
`default_nettype wire

/* design/ordered_record_list_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_record_list_engine_unit
// ordered list of up to ENTRIES records kept in a chain of cells
// ----------------------------------------------------------------------------
// The list lives in a row of ENTRIES cells, slot 0 being the front. An insert
// or a clear needs no walk: on an insert every cell past the insert position
// takes its left neighbour and the addressed cell takes the new record, and
// one result beat follows. Delete and readout rotate the occupied cells one
// place a cycle, a readout step or the last delete step waiting for output
// room: the head record is examined (delete) or sent out (readout) and then
// re-enters at the tail, or is dropped when its key matches. A delete thus
// examines every stored record and then gives its single result beat; a
// readout gives one beat per record, one a cycle while the consumer keeps up.
// The next item is taken once the current one has handed its final beat to
// the output register. An insert into a full list or past the end is reported
// in status and leaves the list alone. Only control state and counts reset.
// ----------------------------------------------------------------------------
module ordered_record_list_engine_unit #(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // position[5:0], rec_key[37:6], rec_name_low[101:38],
  // rec_name_high[117:102], rec_age[125:118], zero pad [127:126]
  input  wire logic [127:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]   in_tuser,
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_key[31:0], out_name_low[95:32], out_name_high[111:96],
  // out_age[119:112], status[121:120], removed[127:122],
  // length[133:128], zero pad [135:134]
  output logic [135:0]      out_tdata,
  // has_record[0]
  output logic              out_tuser,
  output logic              out_tlast
);
  import orle_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned PW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] FULL_LEN = ENTRIES[CW-1:0];
  localparam logic [CW-1:0] ONE      = {{(CW-1){1'b0}}, 1'b1};

  // 6-bit view of a count for the result fields
  function automatic logic [5:0] to6(input logic [CW-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    return w[5:0];
  endfunction

  // control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] len_r, len_nxt;     // entries in the list (delete: live region)
  logic [CW-1:0] rem_r, rem_nxt;     // records still to examine or send
  logic [CW-1:0] gone_r, gone_nxt;   // records dropped so far by a delete
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic signed [31:0] key_r, key_nxt;
  beat_t              beat_r, beat_nxt;

  // input unpacking
  kind_t         in_kind;
  logic [5:0]    in_pos;
  rec_t          new_rec;
  logic [PW-1:0] pos_w;

  assign in_kind            = kind_t'(in_tuser);
  assign in_pos             = in_tdata[5:0];
  assign new_rec.key        = in_tdata[37:6];
  assign new_rec.name_low   = in_tdata[101:38];
  assign new_rec.name_high  = in_tdata[117:102];
  assign new_rec.age        = in_tdata[125:118];
  assign pos_w              = PW'(in_pos);

  // chain
  cell_cmd_t cmd;
  rec_t      cell_q [ENTRIES];
  rec_t      head;
  logic      out_free;
  logic      accept;
  logic      keep;

  assign head = cell_q[0];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rec_t prev_rec;
    rec_t next_rec;
    if (g == 0) begin : g_first
      assign prev_rec = new_rec;
    end else begin : g_mid_prev
      assign prev_rec = cell_q[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign next_rec = cell_q[g];
    end else begin : g_mid_next
      assign next_rec = cell_q[g+1];
    end

    orle_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos_w[CW-1:0]),
      .len      (len_r),
      .new_rec  (new_rec),
      .prev_rec (prev_rec),
      .next_rec (next_rec),
      .head_rec (head),
      .rec_q    (cell_q[g])
    );
  end

  assign out_free  = !out_valid_r || out_tready;
  // items are only taken between walks, with room for the answer
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign keep      = (head.key != key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && len_r != '0) begin
          if (in_kind == KIND_DELETE) begin
            state_nxt = ST_DELETE;
          end else if (in_kind == KIND_READ) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_DELETE: begin
        if (rem_r == ONE && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (rem_r == ONE && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result beats
  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.keep      = 1'b1;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    gone_nxt      = gone_r;
    key_nxt       = key_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          beat_nxt            = '0;
          beat_nxt.last       = 1'b1;
          beat_nxt.length     = to6(len_r);
          case (in_kind)
            KIND_INSERT: begin
              out_valid_nxt = 1'b1;
              if (len_r == FULL_LEN) begin
                beat_nxt.status = STATUS_FULL;
              end else if (pos_w > PW'(len_r)) begin
                beat_nxt.status = STATUS_PAST;
              end else begin
                cmd.op          = CELL_INSERT;
                len_nxt         = len_r + ONE;
                beat_nxt.length = to6(len_r + ONE);
              end
            end
            KIND_DELETE: begin
              key_nxt  = new_rec.key;
              rem_nxt  = len_r;
              gone_nxt = '0;
              // an empty list answers at once
              out_valid_nxt = (len_r == '0);
            end
            KIND_READ: begin
              rem_nxt       = len_r;
              out_valid_nxt = (len_r == '0);
            end
            KIND_CLEAR: begin
              len_nxt         = '0;
              beat_nxt.length = '0;
              out_valid_nxt   = 1'b1;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_DELETE: begin
        // the final step waits for room in the output register
        if (rem_r != ONE || out_free) begin
          cmd.op   = CELL_ROTATE;
          cmd.keep = keep;
          rem_nxt  = rem_r - ONE;
          if (!keep) begin
            len_nxt  = len_r - ONE;
            gone_nxt = gone_r + ONE;
          end
          if (rem_r == ONE) begin
            beat_nxt         = '0;
            beat_nxt.removed = to6(keep ? gone_r : gone_r + ONE);
            beat_nxt.length  = to6(keep ? len_r : len_r - ONE);
            beat_nxt.last    = 1'b1;
            out_valid_nxt    = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd.op              = CELL_ROTATE;
          cmd.keep            = 1'b1;
          rem_nxt             = rem_r - ONE;
          beat_nxt            = '0;
          beat_nxt.rec        = head;
          beat_nxt.has_record = 1'b1;
          beat_nxt.length     = to6(len_r);
          beat_nxt.last       = (rem_r == ONE);
          out_valid_nxt       = 1'b1;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      rem_r       <= '0;
      gone_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      gone_r      <= gone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    beat_r <= beat_nxt;
  end

  // result port packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = beat_r.has_record;
  assign out_tlast  = beat_r.last;
  assign out_tdata  = {2'b00, beat_r.length, beat_r.removed, beat_r.status,
                       beat_r.rec.age, beat_r.rec.name_high,
                       beat_r.rec.name_low, beat_r.rec.key};

  // checks
  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= FULL_LEN)
    else $error("list length beyond capacity");

  a_busy_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (rem_r != '0 && rem_r <= len_r))
    else $error("walk count out of range");

  a_busy_no_take : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("item taken during a walk");

  a_bare_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("beat without record not marked last");

endmodule : ordered_record_list_engine_unit
`default_nettype wire

/* design/orle_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orle_cell
// one list slot: holds a record, takes it from a neighbour, the head or the
// incoming record depending on the broadcast command and its own place
// ----------------------------------------------------------------------------
module orle_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 6
) (
  input  wire logic              clk,
  input  wire orle_pkg::cell_cmd_t cmd,
  input  wire logic [CW-1:0]     pos,
  input  wire logic [CW-1:0]     len,
  input  wire orle_pkg::rec_t    new_rec,
  input  wire orle_pkg::rec_t    prev_rec,
  input  wire orle_pkg::rec_t    next_rec,
  input  wire orle_pkg::rec_t    head_rec,
  output orle_pkg::rec_t         rec_q
);
  import orle_pkg::*;

  localparam logic [CW:0] SELF    = IDX[CW:0];
  localparam logic [CW:0] SELF_P1 = SELF + {{CW{1'b0}}, 1'b1};

  rec_t rec_r;
  rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (SELF == {1'b0, pos}) begin
          rec_nxt = new_rec;
        end else if (SELF > {1'b0, pos} && SELF <= {1'b0, len}) begin
          rec_nxt = prev_rec;
        end
      end
      CELL_ROTATE: begin
        // slots below the tail move one towards the front
        if (SELF_P1 < {1'b0, len}) begin
          rec_nxt = next_rec;
        end else if (SELF_P1 == {1'b0, len} && cmd.keep) begin
          rec_nxt = head_rec;
        end
      end
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_q = rec_r;

endmodule : orle_cell
`default_nettype wire
